// File: src/frg_pkg.sv
// Shared types, constants and control words for the fraction reducer.
package frg_pkg;

    // Width of every operand and result field
    localparam int DATA_WIDTH = 31;
    // Bits needed to count the divider steps, including the full count
    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]      t_count;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD_TEST,
        ST_GCD_WAIT,
        ST_NUM_WAIT,
        ST_DEN_WAIT,
        ST_DONE
    } t_state;

    // Operand pair handed to the shared divider
    typedef enum logic [1:0] {
        DIV_GCD,
        DIV_NUM,
        DIV_DEN
    } t_div_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     load_in;
        logic     div_start;
        t_div_sel div_sel;
        logic     step_gcd;
        logic     latch_num_q;
        logic     latch_den_q;
        logic     set_zero;
        logic     load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic both_zero;
        logic b_zero;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: src/frg_divider.sv
// Restoring divider: one quotient bit per cycle, quotient and remainder held until next start.
module frg_divider (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  frg_pkg::t_data i_dividend,
    input  frg_pkg::t_data i_divisor,
    output logic           o_busy,
    output logic           o_done,
    output frg_pkg::t_data o_quotient,
    output frg_pkg::t_data o_remainder
);
    import frg_pkg::*;

    t_data  r_rem;
    t_data  r_quo;
    t_data  r_dvs;
    t_count r_cnt;
    logic   r_busy;
    logic   r_done;

    logic [DATA_WIDTH:0] w_shift;
    logic [DATA_WIDTH:0] w_diff;
    logic                w_ge;
    t_data               n_rem;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        w_shift = {r_rem, r_quo[DATA_WIDTH-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_diff[DATA_WIDTH-1:0] : w_shift[DATA_WIDTH-1:0];
    end

    // Control: step counter, busy and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - t_count'(1);
                if (r_cnt == t_count'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DATA_WIDTH-2:0], w_ge};
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: src/frg_datapath.sv
// Operand registers, shared divider and output register of the fraction reducer.
module frg_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frg_pkg::t_cmd    i_cmd,
    output frg_pkg::t_status o_status,
    input  frg_pkg::t_data   i_numerator_in,
    input  frg_pkg::t_data   i_denominator_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output frg_pkg::t_data   o_numerator_out,
    output frg_pkg::t_data   o_denominator_out,
    output frg_pkg::t_data   o_common_divisor,
    output logic             o_zero_error
);
    import frg_pkg::*;

    t_data r_num;
    t_data r_den;
    t_data r_a;
    t_data r_b;
    t_data r_qnum;
    t_data r_qden;
    logic  r_zero;

    t_data r_out_num;
    t_data r_out_den;
    t_data r_out_gcd;
    logic  r_out_zero;
    logic  r_out_valid;

    t_data w_dividend;
    t_data w_divisor;
    logic  w_div_busy;
    logic  w_div_done;
    t_data w_quo;
    t_data w_rem;

    // Pick the divider operands; after the loop r_a holds the divisor
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_GCD: begin
                w_dividend = r_a;
                w_divisor  = r_b;
            end
            DIV_NUM: begin
                w_dividend = r_num;
                w_divisor  = r_a;
            end
            DIV_DEN: begin
                w_dividend = r_den;
                w_divisor  = r_a;
            end
            default: begin
                w_dividend = r_a;
                w_divisor  = r_b;
            end
        endcase
    end

    frg_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_busy      (w_div_busy),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Load the fraction, advance Euclid's pair and hold the quotients
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_num  <= i_numerator_in;
            r_den  <= i_denominator_in;
            r_a    <= i_numerator_in;
            r_b    <= i_denominator_in;
            r_zero <= 1'b0;
        end else begin
            if (i_cmd.step_gcd) begin
                r_a <= r_b;
                r_b <= w_rem;
            end
            if (i_cmd.set_zero) begin
                r_zero <= 1'b1;
            end
        end
        if (i_cmd.latch_num_q) begin
            r_qnum <= w_quo;
        end
        if (i_cmd.latch_den_q) begin
            r_qden <= w_quo;
        end
    end

    // Output word register; zero case forces the fields to zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_num  <= r_zero ? '0 : r_qnum;
            r_out_den  <= r_zero ? '0 : r_qden;
            r_out_gcd  <= r_zero ? '0 : r_a;
            r_out_zero <= r_zero;
        end
    end

    // Output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_status.both_zero = (r_a == '0) && (r_b == '0);
        o_status.b_zero    = (r_b == '0);
        o_status.div_busy  = w_div_busy;
        o_status.div_done  = w_div_done;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_numerator_out   = r_out_num;
    assign o_denominator_out = r_out_den;
    assign o_common_divisor  = r_out_gcd;
    assign o_zero_error      = r_out_zero;

endmodule

// File: src/frg_ctrl.sv
// Sequencer that runs Euclid's loop and the two final divisions.
module frg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  frg_pkg::t_status i_status,
    output frg_pkg::t_cmd    o_cmd
);
    import frg_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_status.both_zero ? ST_DONE : ST_GCD_TEST;
            end
            ST_GCD_TEST: begin
                n_state = i_status.b_zero ? ST_NUM_WAIT : ST_GCD_WAIT;
            end
            ST_GCD_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_GCD_TEST;
                end
            end
            ST_NUM_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_DEN_WAIT;
                end
            end
            ST_DEN_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.div_sel = DIV_GCD;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.set_zero = i_status.both_zero;
            end
            ST_GCD_TEST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = i_status.b_zero ? DIV_NUM : DIV_GCD;
            end
            ST_GCD_WAIT: begin
                o_cmd.step_gcd = i_status.div_done;
            end
            ST_NUM_WAIT: begin
                o_cmd.latch_num_q = i_status.div_done;
                o_cmd.div_start   = i_status.div_done;
                o_cmd.div_sel     = DIV_DEN;
            end
            ST_DEN_WAIT: begin
                o_cmd.latch_den_q = i_status.div_done;
            end
            ST_DONE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/fraction_reducer_gcd.sv
// Top level of the fraction reducer: controller, datapath and checks.
//
// Input channel (i_in_valid / o_in_ready) takes one word: a nonnegative
// numerator and denominator. Output channel (o_out_valid / i_out_ready)
// returns one word per input: both parts divided by their greatest common
// divisor, the divisor, and a zero error flag. When both parts are zero the
// flag is set and the three value fields are zero.
// One fraction is processed at a time. Euclid's loop and the two final
// divisions share one restoring divider that produces one quotient bit per
// cycle. Euclid's loop needs at most about 45 remainder steps at 31 bits;
// a zero denominator needs none.
// The result sits in an output register; a new word is accepted in the cycle
// after that register is loaded, even while the receiver stalls. If the
// previous result has not been taken when the next one is ready, the block
// holds in its final state until the receiver takes it.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
// o_out_valid; no item state survives.
module fraction_reducer_gcd (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  frg_pkg::t_data i_numerator_in,
    input  frg_pkg::t_data i_denominator_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output frg_pkg::t_data o_numerator_out,
    output frg_pkg::t_data o_denominator_out,
    output frg_pkg::t_data o_common_divisor,
    output logic           o_zero_error
);
    import frg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    frg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    frg_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_numerator_in    (i_numerator_in),
        .i_denominator_in  (i_denominator_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_numerator_out   (o_numerator_out),
        .o_denominator_out (o_denominator_out),
        .o_common_divisor  (o_common_divisor),
        .o_zero_error      (o_zero_error)
    );

`ifndef SYNTHESIS
    // Output register is only loaded when its previous word is gone
    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_status.out_free)
        else $error("output register overwritten");

    // Divider is never restarted mid-division
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_status.div_busy)
        else $error("divider started while busy");

    // One item at a time: after an accept the input side closes
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted during processing");

    // Divisor is nonzero exactly when no zero error is flagged
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_common_divisor == '0) == o_zero_error))
        else $error("divisor and zero flag disagree");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the fraction reducer: predicts and checks every result word.
`timescale 1ns / 1ps

module tb_top;
    import frg_pkg::*;

    localparam t_data DATA_MAX      = {DATA_WIDTH{1'b1}};
    // Slowest item: about 47 divider passes
    localparam int    ITEM_CYCLES   = 47 * (DATA_WIDTH + 2) + 3;
    localparam int    WATCHDOG_MAX  = 12 * ITEM_CYCLES;
    localparam int    TAIL_CYCLES   = ITEM_CYCLES + 50;
    localparam int    PHASE_ITEMS   = 410;

    // One reduced fraction as the block returns it
    typedef struct {
        t_data num;
        t_data den;
        t_data gcd;
        logic  zero_err;
    } t_reduced;

    class fraction_scoreboard;
        t_reduced reduced_q[$];
        int       mismatches;

        // Print one line and count it
        task report_mismatch(input string what);
            mismatches++;
            $display("[%0t] result check failed: %s", $realtime, what);
        endtask

        // Euclid's remainder loop at the block's width
        function t_data euclid_gcd(input t_data a, input t_data b);
            t_data rem;
            while (b != '0) begin
                rem = a % b;
                a   = b;
                b   = rem;
            end
            return a;
        endfunction

        // Work out the reduced form of an accepted fraction word
        function void note_fraction(input t_data num, input t_data den);
            t_reduced exp_word;
            t_data    g;
            if (num == '0 && den == '0) begin
                exp_word = '{num: '0, den: '0, gcd: '0, zero_err: 1'b1};
            end else begin
                g        = euclid_gcd(num, den);
                exp_word = '{num: num / g, den: den / g, gcd: g, zero_err: 1'b0};
            end
            reduced_q = {reduced_q, exp_word};
        endfunction

        // Compare a returned word against the oldest pending fraction
        task check_result(input t_data num, input t_data den, input t_data gcd,
                          input logic zero_err);
            t_reduced exp_word;
            if (reduced_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d/%0d gcd %0d err %0b",
                                          num, den, gcd, zero_err));
            end else begin
                exp_word = reduced_q.pop_front();
                if (num !== exp_word.num)
                    report_mismatch($sformatf("numerator %0d, want %0d", num, exp_word.num));
                if (den !== exp_word.den)
                    report_mismatch($sformatf("denominator %0d, want %0d", den, exp_word.den));
                if (gcd !== exp_word.gcd)
                    report_mismatch($sformatf("divisor %0d, want %0d", gcd, exp_word.gcd));
                if (zero_err !== exp_word.zero_err)
                    report_mismatch($sformatf("zero flag %0b, want %0b",
                                              zero_err, exp_word.zero_err));
            end
        endtask

        function int pending();
            return reduced_q.size();
        endfunction
    endclass

    logic  i_clk             = 1'b0;
    logic  i_rst_n           = 1'b0;
    logic  i_in_valid        = 1'b0;
    t_data i_numerator_in    = '0;
    t_data i_denominator_in  = '0;
    logic  i_out_ready       = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_data o_numerator_out;
    t_data o_denominator_out;
    t_data o_common_divisor;
    logic  o_zero_error;

    int send_idle_pct = 6;
    int recv_idle_pct = 47;
    int idle_cycles   = 0;

    fraction_scoreboard sb = new;

    fraction_reducer_gcd dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_numerator_in    (i_numerator_in),
        .i_denominator_in  (i_denominator_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_numerator_out   (o_numerator_out),
        .o_denominator_out (o_denominator_out),
        .o_common_divisor  (o_common_divisor),
        .o_zero_error      (o_zero_error)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watch both channels: note accepted fractions, check returned words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_fraction(i_numerator_in, i_denominator_in);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_numerator_out, o_denominator_out, o_common_divisor,
                                o_zero_error);
        end
        // Abort when nothing has moved for too long
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_MAX) begin
            $display("watchdog expired after %0d quiet cycles", WATCHDOG_MAX);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one fraction word, with random idle cycles ahead of it
    task automatic send_fraction(input t_data num, input t_data den);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_numerator_in   <= num;
        i_denominator_in <= den;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Hold the input until every pending result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Consecutive Fibonacci numbers: the longest remainder chains
    task automatic fib_pair(input int n, output t_data hi, output t_data lo);
        longint unsigned a;
        longint unsigned b;
        longint unsigned c;
        a = 1;
        b = 1;
        for (int k = 2; k < n; k++) begin
            c = a + b;
            a = b;
            b = c;
        end
        hi = t_data'(b);
        lo = t_data'(a);
    endtask

    // Draw one random fraction: some full-range, the rest with built-in structure
    task automatic random_fraction(output t_data num, output t_data den);
        longint unsigned g;
        t_data           tmp;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                num = t_data'($urandom());
                den = t_data'($urandom());
            end
            4, 5: begin
                g   = $urandom_range(1, 65535);
                num = t_data'(g * $urandom_range(0, 32767));
                den = t_data'(g * $urandom_range(1, 32767));
            end
            6: begin
                num = t_data'($urandom_range(0, 15));
                den = t_data'($urandom_range(0, 15));
            end
            7: begin
                num = '0;
                den = t_data'($urandom());
            end
            8: begin
                num = t_data'($urandom());
                den = num;
            end
            default: begin
                fib_pair($urandom_range(2, 46), num, den);
            end
        endcase
        if ($urandom_range(0, 1)) begin
            tmp = num;
            num = den;
            den = tmp;
        end
    endtask

    initial begin
        t_data num;
        t_data den;

        // Hold reset, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: zeros, extremes, longest chains, shared factors
        send_fraction('0, '0);
        send_fraction('0, 31'd5);
        send_fraction(31'd7, '0);
        send_fraction('0, DATA_MAX);
        send_fraction(DATA_MAX, '0);
        send_fraction(DATA_MAX, DATA_MAX);
        send_fraction(DATA_MAX, 31'd1);
        send_fraction(31'd1, DATA_MAX);
        send_fraction(31'd1, 31'd1);
        send_fraction(DATA_MAX, DATA_MAX - 31'd1);
        send_fraction(31'd1836311903, 31'd1134903170);
        send_fraction(31'd1134903170, 31'd1836311903);
        send_fraction(31'h4000_0000, 31'h6000_0000);
        send_fraction(31'h5555_5555, 31'h2AAA_AAAA);
        send_fraction(31'd12, 31'd18);
        send_fraction(31'd100, 31'd75);
        send_fraction('0, '0);
        send_fraction(31'd6, 31'd4);
        drain_results();

        // Random fractions over three idle patterns, draining between them
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct <= (phase == 0) ? 6 : (phase == 1) ? 47 : 0;
            recv_idle_pct <= (phase == 0) ? 47 : (phase == 1) ? 6 : 0;
            @(posedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_fraction(num, den);
                send_fraction(num, den);
            end
            drain_results();
        end

        // Let any stray words surface before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
